FILE: hw/rtl/qdd_pkg.sv
`default_nettype none
package qdd_pkg;

    localparam int unsigned PhaseWidth  = 2;
    localparam int unsigned CountWidth  = 4;
    localparam int unsigned CfgWidth    = 4;
    localparam int unsigned DetentWidth = 2;

    // Register map
    localparam logic CfgDebounceThreshold = 1'b0;
    localparam logic CfgStepsPerDetent    = 1'b1;

    // Request kinds carried on tuser
    localparam logic ReqPoll   = 1'b0;
    localparam logic ReqResync = 1'b1;

    typedef logic [PhaseWidth-1:0] phase_t;

    typedef struct packed {
        phase_t                        accepted_phase;
        phase_t                        candidate_phase;
        logic        [CountWidth-1:0]  stable_run;
        logic signed [CountWidth-1:0]  step_sum;
    } qdd_state_t;

    // Quarter step for an old/new phase pair: Gray code order 0,1,3,2
    function automatic logic signed [1:0] gray_step(input phase_t old_ph, input phase_t new_ph);
        logic signed [1:0] dir;
        begin
            case ({old_ph, new_ph})
                4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = 2'sd1;
                4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = -2'sd1;
                default:                            dir = 2'sd0;
            endcase
            return dir;
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/quadrature_detent_decoder.sv
// Quadrature detent decoder with debounce.
//
// Input stream (s_*): one beat per encoder sample. tdata carries line_a in
// bit 0 and line_b in bit 1; tuser selects a poll sample (0) or a resync
// to the current line levels (1). Output stream (m_*): exactly one beat per
// input beat, tdata[1:0] a signed detent of +1, -1 or 0.
// Configuration: cfg_we/cfg_index/cfg_data write debounce_threshold (0)
// and steps_per_detent (1); write only while the stream is idle.
//
// A beat passes from the input register, through the state update, into
// the result register and out as the output beat. A new beat is taken
// every cycle while the receiver accepts results; the debounce and
// step-sum registers are updated once for each beat that moves on.
// When the receiver stalls, the result register holds its beat and the
// input register holds one more; s_tready drops only when both are full.
// Reset clears the phase, run and sum state, empties both registers and
// loads threshold 2 and steps per detent 2.
`default_nettype none
module quadrature_detent_decoder
    import qdd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] line_a, [1] line_b, rest zero
    input  wire logic                 s_tuser,   // [0] req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [1:0] detent (signed), rest zero
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CfgWidth-1:0]  cfg_data
);

    logic                          in_valid_reg;
    logic                          in_req_reg;
    phase_t                        in_phase_reg;
    logic                          out_valid_reg;
    logic signed [DetentWidth-1:0] out_detent_reg;
    logic [CfgWidth-1:0]           threshold_reg;
    logic [CfgWidth-1:0]           spd_reg;
    qdd_state_t                    state_reg;
    qdd_state_t                    state_next;
    logic signed [DetentWidth-1:0] detent_next;
    logic                          advance;
    logic                          s_beat;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= CfgWidth'(2);
            spd_reg       <= CfgWidth'(2);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CfgDebounceThreshold)
                threshold_reg <= cfg_data;
            else
                spd_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_req_reg   <= s_tuser;
            in_phase_reg <= {s_tdata[1], s_tdata[0]};
        end
    end

    qdd_step u_step (
        .state              (state_reg),
        .resync             (in_req_reg),
        .phase              (in_phase_reg),
        .debounce_threshold (threshold_reg),
        .steps_per_detent   (spd_reg),
        .state_next         (state_next),
        .detent             (detent_next)
    );

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_detent_reg <= detent_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8-DetentWidth){1'b0}}, out_detent_reg};

endmodule
`default_nettype wire

FILE: hw/rtl/qdd_step.sv
`default_nettype none
module qdd_step
    import qdd_pkg::*;
(
    input  wire qdd_state_t                     state,
    input  wire logic                           resync,
    input  wire phase_t                         phase,
    input  wire logic [CfgWidth-1:0]            debounce_threshold,
    input  wire logic [CfgWidth-1:0]            steps_per_detent,
    output qdd_state_t                          state_next,
    output logic signed [DetentWidth-1:0]       detent
);

    logic        [CountWidth-1:0] thr;
    logic signed [CountWidth:0]   spd;
    logic        [CountWidth:0]   run;
    logic signed [1:0]            dir;
    logic signed [CountWidth:0]   sum;

    // Clamp configuration into its working range
    always_comb
    begin
        thr = (debounce_threshold == '0) ? CountWidth'(1) : debounce_threshold;
        if (steps_per_detent == '0)
            spd = (CountWidth+1)'(1);
        else if (steps_per_detent > CfgWidth'(8))
            spd = (CountWidth+1)'(8);
        else
            spd = $signed({1'b0, steps_per_detent});
    end

    assign run = {1'b0, state.stable_run} + (CountWidth+1)'(1);
    assign dir = gray_step(state.accepted_phase, phase);
    assign sum = {state.step_sum[CountWidth-1], state.step_sum}
               + {{(CountWidth-1){dir[1]}}, dir};

    // Debounce, direction decode and detent accumulation
    always_comb
    begin
        state_next = state;
        detent     = '0;
        if (resync == ReqResync)
        begin
            state_next.accepted_phase  = phase;
            state_next.candidate_phase = phase;
            state_next.stable_run      = '0;
            state_next.step_sum        = '0;
        end
        else if (phase != state.candidate_phase)
        begin
            state_next.candidate_phase = phase;
            state_next.stable_run      = CountWidth'(1);
        end
        else if (run < {1'b0, thr})
        begin
            state_next.stable_run = run[CountWidth-1:0];
        end
        else
        begin
            state_next.stable_run = thr;
            if (phase != state.accepted_phase)
            begin
                state_next.accepted_phase = phase;
                if (dir != 2'sd0)
                begin
                    if (sum >= spd)
                    begin
                        state_next.step_sum = '0;
                        detent              = 2'sd1;
                    end
                    else if (sum <= -spd)
                    begin
                        state_next.step_sum = '0;
                        detent              = -2'sd1;
                    end
                    else
                    begin
                        state_next.step_sum = sum[CountWidth-1:0];
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire
